// File: design/packet_fifo_byte_budget_defines.svh
// Assertion helpers used by the packet FIFO executor RTL (pfb_back).
`ifndef PACKET_FIFO_BYTE_BUDGET_DEFINES_SVH
`define PACKET_FIFO_BYTE_BUDGET_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define PFB_ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define PFB_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: design/pfb_pkg.sv
`default_nettype none
package pfb_pkg;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 7;
    localparam int LIMIT_W = 11;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    // Command handed from the front end to the executor.
    typedef struct packed {
        logic              is_read;
        logic              first;    // first byte of a written packet
        logic              len_ok;   // declared length in 1..MAX_PACKET
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
        logic              last;
    } t_cmd;

    typedef struct packed {
        logic [1:0]        kind;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
        logic              last;
    } t_result;

endpackage
`default_nettype wire

// File: design/packet_fifo_byte_budget.sv
// Packet FIFO with a byte budget.
// Input channel (i_valid / o_stall): one transaction per packet byte (i_op = 0) or per
// read request (i_op = 1). A byte transaction carries the declared packet length and a
// last-byte flag; the first byte decides acceptance against length range, occupancy, i_cfg_data limit,
// free store space and descriptor room. The final byte yields one ack transaction with
// the stored length (0 when rejected). A read yields every byte of the oldest packet,
// o_last on the final one, or a single empty transaction.
// Output channel (o_valid / i_stall): o_kind, o_data_byte_out, o_length_out, o_last.
// Config: i_cfg_we writes the byte limit from i_cfg_data; write only while idle.
// Throughput: byte writes run one per cycle while the result queue has room for acks.
// A read occupies the executor for a length fetch, one byte per cycle while the result
// queue has credit, and a RAM drain, bounded by the single registered byte store read port.
// Path: an ack passes through the command queue and the result queue; the first read byte
// through the command queue, length fetch, byte store read and the result queue.
// Reset (synchronous, active low) empties the command and result queues, clears
// pointers and counts and restores the byte limit to 1024; store contents are left as is.
// A stalled receiver fills the two-entry result queue, which halts the executor at its next
// ack or read; the two-entry command queue then fills and o_stall rises.
`default_nettype none
module packet_fifo_byte_budget #(
    parameter int DATA_DEPTH = 1024,
    parameter int DESC_DEPTH = 256,
    parameter int MAX_PACKET = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // configuration
    input  wire logic                        i_cfg_we,
    input  wire logic [pfb_pkg::LIMIT_W-1:0] i_cfg_data,
    // input channel
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic                        i_op,
    input  wire logic [pfb_pkg::BYTE_W-1:0]  i_data_byte,
    input  wire logic [pfb_pkg::LEN_W-1:0]   i_packet_length,
    input  wire logic                        i_last_byte,
    // output channel
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [1:0]                       o_kind,
    output logic [pfb_pkg::BYTE_W-1:0]       o_data_byte_out,
    output logic [pfb_pkg::LEN_W-1:0]        o_length_out,
    output logic                             o_last
);
    import pfb_pkg::*;

    t_cmd cmd;
    logic cmd_valid;
    logic cmd_take;

    // Front end: tags first bytes and length sanity, buffers commands.
    pfb_front #(
        .MAX_PACKET (MAX_PACKET)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_op            (i_op),
        .i_data_byte     (i_data_byte),
        .i_packet_length (i_packet_length),
        .i_last_byte     (i_last_byte),
        .o_cmd_valid     (cmd_valid),
        .i_cmd_take      (cmd_take),
        .o_cmd           (cmd)
    );

    // Executor: owns the rings, budget and result queue.
    pfb_back #(
        .DATA_DEPTH (DATA_DEPTH),
        .DESC_DEPTH (DESC_DEPTH),
        .MAX_PACKET (MAX_PACKET)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_cmd_valid     (cmd_valid),
        .i_cmd           (cmd),
        .o_cmd_take      (cmd_take),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_kind          (o_kind),
        .o_data_byte_out (o_data_byte_out),
        .o_length_out    (o_length_out),
        .o_last          (o_last)
    );

endmodule
`default_nettype wire

// File: design/pfb_ram.sv
`default_nettype none
module pfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// File: design/pfb_front.sv
`default_nettype none
module pfb_front #(
    parameter int MAX_PACKET = 64
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic                      i_op,
    input  wire logic [pfb_pkg::BYTE_W-1:0] i_data_byte,
    input  wire logic [pfb_pkg::LEN_W-1:0]  i_packet_length,
    input  wire logic                      i_last_byte,
    output logic                           o_cmd_valid,
    input  wire logic                      i_cmd_take,
    output pfb_pkg::t_cmd                  o_cmd
);
    import pfb_pkg::*;

    logic       r_in_packet;
    t_cmd       r_q [2];
    logic       r_qwp;
    logic       r_qrp;
    logic [1:0] r_qcnt;
    logic       push;
    logic       is_wr;
    t_cmd       cmd;

    assign o_stall     = (r_qcnt == 2'd2);
    assign push        = i_valid && !o_stall;
    assign is_wr       = (i_op == OP_WRITE);
    assign o_cmd_valid = (r_qcnt != 2'd0);
    assign o_cmd       = r_q[r_qrp];

    always_comb begin
        cmd.is_read = (i_op == OP_READ);
        cmd.first   = is_wr && !r_in_packet;
        cmd.len_ok  = (i_packet_length != '0) &&
                      (i_packet_length <= LEN_W'(MAX_PACKET));
        cmd.data    = i_data_byte;
        cmd.len     = i_packet_length;
        cmd.last    = i_last_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_packet <= 1'b0;
            r_qwp       <= 1'b0;
            r_qrp       <= 1'b0;
            r_qcnt      <= 2'd0;
        end else begin
            if (push && is_wr) begin
                r_in_packet <= !i_last_byte;
            end
            if (push) begin
                r_qwp <= !r_qwp;
            end
            if (i_cmd_take) begin
                r_qrp <= !r_qrp;
            end
            r_qcnt <= r_qcnt + 2'(push) - 2'(i_cmd_take);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_qwp] <= cmd;
        end
    end

endmodule
`default_nettype wire

// File: design/pfb_back.sv
`default_nettype none
`include "packet_fifo_byte_budget_defines.svh"
module pfb_back #(
    parameter int DATA_DEPTH = 1024,
    parameter int DESC_DEPTH = 256,
    parameter int MAX_PACKET = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [pfb_pkg::LIMIT_W-1:0] i_cfg_data,
    input  wire logic                        i_cmd_valid,
    input  wire pfb_pkg::t_cmd               i_cmd,
    output logic                             o_cmd_take,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [1:0]                       o_kind,
    output logic [pfb_pkg::BYTE_W-1:0]       o_data_byte_out,
    output logic [pfb_pkg::LEN_W-1:0]        o_length_out,
    output logic                             o_last
);
    import pfb_pkg::*;

    localparam int AW    = $clog2(DATA_DEPTH);
    localparam int DAW   = $clog2(DESC_DEPTH);
    localparam int OCC_W = $clog2(DATA_DEPTH + 1);
    localparam int DC_W  = $clog2(DESC_DEPTH + 1);
    localparam int CMP_W = (OCC_W > LIMIT_W) ? OCC_W : LIMIT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LEN,
        S_BYTES,
        S_DRAIN
    } t_state;

    t_state             r_state, n_state;
    logic [LIMIT_W-1:0] r_limit;
    logic               r_acc, n_acc;
    logic [LEN_W-1:0]   r_cur_len, n_cur_len;
    logic [LEN_W-1:0]   r_cur_cnt, n_cur_cnt;
    logic [AW-1:0]      r_wp, n_wp;
    logic [AW-1:0]      r_rp, n_rp;
    logic [DAW-1:0]     r_dhead, n_dhead;
    logic [DAW-1:0]     r_dtail, n_dtail;
    logic [DC_W-1:0]    r_dcount, n_dcount;
    logic [OCC_W-1:0]   r_occ, n_occ;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [LEN_W-1:0]   r_idx, n_idx;
    logic               r_infl;
    logic               r_infl_last;

    // result queue, two entries
    t_result            r_ofifo [2];
    logic               r_owp;
    logic               r_orp;
    logic [1:0]         r_ocnt;

    logic               pop, room, credit, need_room;
    logic [2:0]         next_cnt;
    logic               push_imm, push;
    t_result            imm_res, land_res, push_res;
    logic               issue, idx_last;
    logic               len_re;
    logic               byte_we, len_we;
    logic [BYTE_W-1:0]  byte_rdata;
    logic [LEN_W-1:0]   len_rdata, len_clamped;
    logic [OCC_W-1:0]   free_bytes;
    logic               acc_w, store;
    logic [LEN_W-1:0]   clen_w, ccnt_w, cnt_new;

    // write path classification against committed state
    assign free_bytes = OCC_W'(DATA_DEPTH) - r_occ;
    assign acc_w  = i_cmd.first ? (i_cmd.len_ok &&
                                   (CMP_W'(r_occ) < CMP_W'(r_limit)) &&
                                   (CMP_W'(i_cmd.len) <= CMP_W'(free_bytes)) &&
                                   (r_dcount < DC_W'(DESC_DEPTH)))
                                : r_acc;
    assign clen_w  = i_cmd.first ? i_cmd.len : r_cur_len;
    assign ccnt_w  = i_cmd.first ? '0 : r_cur_cnt;
    assign store   = acc_w && (ccnt_w < clen_w);
    assign cnt_new = ccnt_w + LEN_W'(store);

    assign len_clamped = (len_rdata > LEN_W'(MAX_PACKET)) ? LEN_W'(MAX_PACKET) : len_rdata;
    assign idx_last    = (r_idx == (r_len - 1'b1));

    assign o_valid   = (r_ocnt != 2'd0);
    assign pop       = o_valid && !i_stall;
    assign room      = (r_ocnt != 2'd2) || pop;
    assign next_cnt  = {1'b0, r_ocnt} - 3'(pop) + 3'(r_infl);
    assign credit    = (next_cnt < 3'd2);
    assign need_room = i_cmd.is_read ? (r_dcount == '0) : i_cmd.last;

    assign land_res = '{kind: KIND_DATA, data: byte_rdata, len: r_len, last: r_infl_last};
    assign push     = push_imm || r_infl;
    assign push_res = r_infl ? land_res : imm_res;

    assign o_kind          = r_ofifo[r_orp].kind;
    assign o_data_byte_out = r_ofifo[r_orp].data;
    assign o_length_out    = r_ofifo[r_orp].len;
    assign o_last          = r_ofifo[r_orp].last;

    always_comb begin
        n_state    = r_state;
        n_acc      = r_acc;
        n_cur_len  = r_cur_len;
        n_cur_cnt  = r_cur_cnt;
        n_wp       = r_wp;
        n_rp       = r_rp;
        n_dhead    = r_dhead;
        n_dtail    = r_dtail;
        n_dcount   = r_dcount;
        n_occ      = r_occ;
        n_len      = r_len;
        n_idx      = r_idx;
        o_cmd_take = 1'b0;
        push_imm   = 1'b0;
        imm_res    = '{kind: KIND_EMPTY, data: '0, len: '0, last: 1'b1};
        issue      = 1'b0;
        byte_we    = 1'b0;
        len_we     = 1'b0;
        len_re     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && (!need_room || room)) begin
                    o_cmd_take = 1'b1;
                    if (i_cmd.is_read) begin
                        if (r_dcount == '0) begin
                            push_imm = 1'b1;
                        end else begin
                            len_re  = 1'b1;
                            n_state = S_LEN;
                        end
                    end else begin
                        if (store) begin
                            byte_we = 1'b1;
                            n_wp    = (r_wp == AW'(DATA_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                            n_occ   = r_occ + 1'b1;
                        end
                        if (i_cmd.last) begin
                            if (acc_w) begin
                                len_we   = 1'b1;
                                n_dtail  = (r_dtail == DAW'(DESC_DEPTH - 1)) ? '0
                                                                            : r_dtail + 1'b1;
                                n_dcount = r_dcount + 1'b1;
                            end
                            push_imm  = 1'b1;
                            imm_res   = '{kind: KIND_ACK, data: '0,
                                          len: (acc_w ? cnt_new : '0), last: 1'b1};
                            n_acc     = 1'b0;
                            n_cur_len = '0;
                            n_cur_cnt = '0;
                        end else begin
                            n_acc     = acc_w;
                            n_cur_len = clen_w;
                            n_cur_cnt = cnt_new;
                        end
                    end
                end
            end
            S_LEN: begin
                n_len    = len_clamped;
                n_idx    = '0;
                n_dhead  = (r_dhead == DAW'(DESC_DEPTH - 1)) ? '0 : r_dhead + 1'b1;
                n_dcount = r_dcount - 1'b1;
                n_occ    = (r_occ >= OCC_W'(len_clamped)) ? r_occ - OCC_W'(len_clamped) : '0;
                n_state  = S_BYTES;
            end
            S_BYTES: begin
                if (r_len == '0) begin
                    // zero-length descriptor reads as empty
                    if (room) begin
                        push_imm = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else if (credit) begin
                    issue = 1'b1;
                    n_rp  = (r_rp == AW'(DATA_DEPTH - 1)) ? '0 : r_rp + 1'b1;
                    n_idx = r_idx + 1'b1;
                    if (idx_last) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= LIMIT_RESET;
            r_acc       <= 1'b0;
            r_cur_len   <= '0;
            r_cur_cnt   <= '0;
            r_wp        <= '0;
            r_rp        <= '0;
            r_dhead     <= '0;
            r_dtail     <= '0;
            r_dcount    <= '0;
            r_occ       <= '0;
            r_len       <= '0;
            r_idx       <= '0;
            r_infl      <= 1'b0;
            r_infl_last <= 1'b0;
            r_owp       <= 1'b0;
            r_orp       <= 1'b0;
            r_ocnt      <= 2'd0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            r_acc       <= n_acc;
            r_cur_len   <= n_cur_len;
            r_cur_cnt   <= n_cur_cnt;
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_dhead     <= n_dhead;
            r_dtail     <= n_dtail;
            r_dcount    <= n_dcount;
            r_occ       <= n_occ;
            r_len       <= n_len;
            r_idx       <= n_idx;
            r_infl      <= issue;
            r_infl_last <= issue && idx_last;
            if (push) begin
                r_owp <= !r_owp;
            end
            if (pop) begin
                r_orp <= !r_orp;
            end
            r_ocnt <= r_ocnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ofifo[r_owp] <= push_res;
        end
    end

    pfb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DATA_DEPTH)
    ) u_byte_store (
        .i_clk   (i_clk),
        .i_we    (byte_we),
        .i_waddr (r_wp),
        .i_wdata (i_cmd.data),
        .i_re    (issue),
        .i_raddr (r_rp),
        .o_rdata (byte_rdata)
    );

    pfb_ram #(
        .WIDTH (LEN_W),
        .DEPTH (DESC_DEPTH)
    ) u_length_queue (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (r_dtail),
        .i_wdata (cnt_new),
        .i_re    (len_re),
        .i_raddr (r_dhead),
        .o_rdata (len_rdata)
    );

    `PFB_ASSERT_NEVER(a_ofifo_overflow, i_clk, i_rst_n, push && !pop && (r_ocnt == 2'd2), "result queue overflow")
    `PFB_ASSERT_NEVER(a_push_collide, i_clk, i_rst_n, push_imm && r_infl, "status result collides with read data")
    `PFB_ASSERT_PROP(a_drain_infl, i_clk, i_rst_n, (r_state == S_DRAIN) |-> r_infl, "drain without byte in flight")
    `PFB_ASSERT_NEVER(a_occ_range, i_clk, i_rst_n, r_occ > OCC_W'(DATA_DEPTH), "occupancy above store depth")
    `PFB_ASSERT_NEVER(a_desc_range, i_clk, i_rst_n, r_dcount > DC_W'(DESC_DEPTH), "descriptor count above depth")

endmodule
`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps

// Packet FIFO byte-budget bench.
// Write transactions stream packet bytes. Read transactions pull out the oldest
// committed packet. A shadow copy of the FIFO (stores, pointers, occupancy, limit)
// runs alongside the block and works out the results of each accepted transaction.
// The monitor pops them in order and compares them field by field.
module testbench;
    import pfb_pkg::*;

    localparam int STORE_DEPTH   = 1024;
    localparam int DESC_SLOTS    = 256;
    localparam int PKT_MAX       = 64;
    localparam int SETTLE_CYCLES = 30;    // covers ack and first-read-byte latency
    localparam int QUIET_LIMIT   = 1000;  // cycles with no transaction on either side
    localparam int PRINT_CAP     = 40;

    typedef struct {
        logic              op;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  plen;
        logic              lastb;
    } t_fifo_cmd;

    // ------------------------------------------------------------------
    // DUT hookup. Every input has a known value from time 0.
    // ------------------------------------------------------------------
    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_cfg_we        = 1'b0;
    logic [LIMIT_W-1:0] i_cfg_data      = '0;
    logic               i_valid         = 1'b0;
    logic               i_op            = OP_WRITE;
    logic [BYTE_W-1:0]  i_data_byte     = '0;
    logic [LEN_W-1:0]   i_packet_length = '0;
    logic               i_last_byte     = 1'b0;
    logic               i_stall         = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [1:0]         o_kind;
    logic [BYTE_W-1:0]  o_data_byte_out;
    logic [LEN_W-1:0]   o_length_out;
    logic               o_last;

    packet_fifo_byte_budget #(
        .DATA_DEPTH (STORE_DEPTH),
        .DESC_DEPTH (DESC_SLOTS),
        .MAX_PACKET (PKT_MAX)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_op            (i_op),
        .i_data_byte     (i_data_byte),
        .i_packet_length (i_packet_length),
        .i_last_byte     (i_last_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_kind          (o_kind),
        .o_data_byte_out (o_data_byte_out),
        .o_length_out    (o_length_out),
        .o_last          (o_last)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow FIFO. Ring pointers are sized so they wrap at the store depths.
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0]             shadow_bytes [STORE_DEPTH];
    logic [LEN_W-1:0]              shadow_lens  [DESC_SLOTS];
    logic [$clog2(STORE_DEPTH)-1:0] byte_wr  = '0;
    logic [$clog2(STORE_DEPTH)-1:0] byte_rd  = '0;
    logic [$clog2(DESC_SLOTS)-1:0]  desc_wr  = '0;
    logic [$clog2(DESC_SLOTS)-1:0]  desc_rd  = '0;
    int                             desc_cnt   = 0;
    int                             occupancy  = 0;
    bit                             pkt_open   = 1'b0;
    bit                             pkt_taken  = 1'b0;
    int                             pkt_len    = 0;
    int                             pkt_stored = 0;
    logic [LIMIT_W-1:0]             byte_limit = LIMIT_RESET;

    t_fifo_cmd fifo_cmds_to_send [$];
    t_result   owed_results      [$];
    int        mismatch_count = 0;

    // Shadow update for one accepted input transaction; queues what it owes.
    task automatic step_budget_fifo(input t_fifo_cmd c);
        t_result r;
        int      n;
        r      = '0;
        r.last = 1'b1;
        if (c.op == OP_WRITE) begin
            // admission is decided once, on the first byte
            if (!pkt_open) begin
                pkt_open   = 1'b1;
                pkt_len    = int'(c.plen);
                pkt_stored = 0;
                pkt_taken  = pkt_len >= 1 && pkt_len <= PKT_MAX &&
                             occupancy < int'(byte_limit) &&
                             pkt_len <= STORE_DEPTH - occupancy &&
                             desc_cnt < DESC_SLOTS;
            end
            // bytes past the latched length are dropped
            if (pkt_taken && pkt_stored < pkt_len) begin
                shadow_bytes[byte_wr] = c.data;
                byte_wr++;
                pkt_stored++;
                occupancy++;
            end
            if (c.lastb) begin
                r.kind = KIND_ACK;
                if (pkt_taken) begin
                    shadow_lens[desc_wr] = LEN_W'(pkt_stored);
                    desc_wr++;
                    desc_cnt++;
                    r.len = LEN_W'(pkt_stored);
                end
                owed_results.push_back(r);
                pkt_open  = 1'b0;
                pkt_taken = 1'b0;
            end
        end else if (desc_cnt == 0) begin
            r.kind = KIND_EMPTY;
            owed_results.push_back(r);
        end else begin
            n = int'(shadow_lens[desc_rd]);
            desc_rd++;
            desc_cnt--;
            for (int i = 0; i < n; i++) begin
                r.kind = KIND_DATA;
                r.data = shadow_bytes[byte_rd];
                r.len  = LEN_W'(n);
                r.last = (i == n - 1);
                owed_results.push_back(r);
                byte_rd++;
            end
            occupancy -= n;
        end
    endtask

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_CAP)
            $display("MISMATCH @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Driver: presents queued transactions, random gap after each one.
    // cmd_in_flight is blocking so the sequencer sees it without a race.
    // ------------------------------------------------------------------
    t_fifo_cmd on_wire;
    bit        cmd_in_flight = 1'b0;
    int        send_gap      = 0;
    bit        send_burst    = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                step_budget_fifo(on_wire);
                cmd_in_flight = 1'b0;
            end
            // a stalled payload holds; otherwise load the next one or idle
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (fifo_cmds_to_send.size() != 0) begin
                    on_wire         = fifo_cmds_to_send.pop_front();
                    cmd_in_flight   = 1'b1;
                    i_op            <= on_wire.op;
                    i_data_byte     <= on_wire.data;
                    i_packet_length <= on_wire.plen;
                    i_last_byte     <= on_wire.lastb;
                    i_valid         <= 1'b1;
                    // occasional back-to-back stretches
                    if ($urandom_range(0, 39) == 0)
                        send_burst = !send_burst;
                    send_gap = send_burst ? 0 : $urandom_range(0, 8);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result transaction, then stalls a random while.
    // ------------------------------------------------------------------
    t_result want;
    int      hold_left  = 0;
    bit      recv_burst = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (owed_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result kind=%0d data=%0h len=%0d",
                                              o_kind, o_data_byte_out, o_length_out));
                end else begin
                    want = owed_results.pop_front();
                    if (o_kind !== want.kind)
                        report_mismatch($sformatf("kind %0d, want %0d", o_kind, want.kind));
                    if (o_data_byte_out !== want.data)
                        report_mismatch($sformatf("data %0h, want %0h",
                                                  o_data_byte_out, want.data));
                    if (o_length_out !== want.len)
                        report_mismatch($sformatf("length %0d, want %0d",
                                                  o_length_out, want.len));
                    if (o_last !== want.last)
                        report_mismatch($sformatf("last %0b, want %0b", o_last, want.last));
                end
                if ($urandom_range(0, 39) == 0)
                    recv_burst = !recv_burst;
                hold_left = recv_burst ? 0 : $urandom_range(0, 8);
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog: too long without any transaction means a hang.
    int quiet = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
                if (quiet >= QUIET_LIMIT) begin
                    $display("packet_fifo_byte_budget verification failed");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic add_read();
        t_fifo_cmd c;
        c.op    = OP_READ;
        c.data  = BYTE_W'($urandom);   // ignored on reads; random noise
        c.plen  = LEN_W'($urandom);
        c.lastb = 1'($urandom);
        fifo_cmds_to_send.push_back(c);
    endtask

    // nbytes write transactions declaring decl; vary_len scrambles the length
    // after the first byte, mid_reads sprinkles reads inside the packet.
    task automatic add_packet(input int decl, input int nbytes, input bit vary_len,
                              input bit mid_reads);
        t_fifo_cmd c;
        for (int i = 0; i < nbytes; i++) begin
            c.op    = OP_WRITE;
            c.data  = BYTE_W'($urandom);
            c.plen  = (i > 0 && vary_len) ? LEN_W'($urandom_range(0, 127)) : LEN_W'(decl);
            c.lastb = (i == nbytes - 1);
            fifo_cmds_to_send.push_back(c);
            if (mid_reads && !c.lastb && $urandom_range(0, 9) == 0)
                add_read();
        end
    endtask

    // Mostly well-formed packets of biased length, plus reads and malformed packets.
    task automatic add_random_mix(input int n_items);
        int target;
        int decl;
        int nbytes;
        int pick;
        bit vary;
        target = fifo_cmds_to_send.size() + n_items;
        while (fifo_cmds_to_send.size() < target) begin
            if ($urandom_range(0, 99) < 35) begin
                add_read();
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 65)
                    decl = $urandom_range(1, 6);
                else if (pick < 90)
                    decl = $urandom_range(7, PKT_MAX - 1);
                else
                    decl = PKT_MAX;
                nbytes = decl;
                vary   = 1'b0;
                pick   = $urandom_range(0, 99);
                if (pick < 8) begin
                    nbytes = (decl > 1) ? $urandom_range(1, decl - 1) : 1;   // early last
                end else if (pick < 14) begin
                    nbytes = decl + $urandom_range(1, 6);                     // overrun
                end else if (pick < 20) begin
                    vary = 1'b1;
                end else if (pick < 26) begin
                    decl   = $urandom_range(0, 1) ? 0 : $urandom_range(PKT_MAX + 1, 127);
                    nbytes = $urandom_range(1, 4);
                end
                add_packet(decl, nbytes, vary, 1'b1);
            end
        end
    endtask

    // Everything sent, every result back, plus slack for stray output.
    task automatic wait_drained();
        while (fifo_cmds_to_send.size() != 0 || cmd_in_flight || owed_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure_limit(input logic [LIMIT_W-1:0] v);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        byte_limit = v;
    endtask

    // ------------------------------------------------------------------
    // Sequence of phases
    // ------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset limit
        add_read();                                  // read with nothing committed
        add_packet(1, 1, 1'b0, 1'b0);
        fifo_cmds_to_send[$].data = 8'hFF;
        add_packet(0, 1, 1'b0, 1'b0);                // zero length: rejected
        add_packet(127, 1, 1'b0, 1'b0);              // all-ones length: rejected
        add_packet(PKT_MAX + 1, 1, 1'b0, 1'b0);      // just over max: rejected
        add_packet(3, 2, 1'b0, 1'b0);                // last byte arrives early
        add_packet(2, 4, 1'b0, 1'b0);                // extra bytes dropped
        fifo_cmds_to_send[$-3].data = 8'h00;
        add_packet(2, 3, 1'b1, 1'b0);                // length field changes mid-packet
        repeat (5) add_read();                       // drain, final one finds it empty

        // Limit zero: everything rejected
        configure_limit('0);
        add_random_mix(30);

        // Limit one: accepts only into an empty store
        configure_limit(LIMIT_W'(1));
        add_random_mix(40);

        // Tight budget: occupancy hits the limit often
        configure_limit(LIMIT_W'($urandom_range(20, 200)));
        add_random_mix(90);

        // Random budget
        configure_limit(LIMIT_W'($urandom_range(0, 1024)));
        add_random_mix(90);

        wait_drained();
        if (mismatch_count == 0)
            $display("packet_fifo_byte_budget verification clean");
        else
            $display("packet_fifo_byte_budget verification failed");
        $finish;
    end

endmodule
